FILE: rtl/core/stl_pkg.sv
`timescale 1ns / 1ps
package stl_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int FUNC_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 7;

  localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_FIND    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REVERSE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DUMP    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    RT_IDLE  = 2'd0,
    RT_READ  = 2'd1,
    RT_PLACE = 2'd2,
    RT_RES   = 2'd3
  } route_e;

  typedef struct packed {
    logic load;
    logic read;
    logic eval;
    logic place;
    logic result;
  } stl_cmd_t;

  typedef struct packed {
    route_e start_route;
    route_e eval_next;
    logic   eval_ok;
    logic   out_free;
  } stl_stat_t;

endpackage

FILE: rtl/core/stl_if.sv
`timescale 1ns / 1ps
interface stl_in_if;
  import stl_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [FUNC_W-1:0]             func;
  logic signed [VALUE_WIDTH-1:0] value;
  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface stl_out_if;
  import stl_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [STATUS_W-1:0]           status;
  logic [POS_W-1:0]              position;
  logic signed [VALUE_WIDTH-1:0] item_value;
  logic [POS_W-1:0]              entry_count;
  logic                          last;
  modport source (output valid, status, position, item_value, entry_count, last, input ready);
  modport sink   (input valid, status, position, item_value, entry_count, last, output ready);
endinterface

FILE: rtl/core/stl_ram.sv
`timescale 1ns / 1ps
module stl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

FILE: rtl/core/stl_datapath.sv
`timescale 1ns / 1ps
module stl_datapath
  import stl_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [FUNC_W-1:0]             in_func_i,
  input  logic signed [VALUE_WIDTH-1:0] in_value_i,
  input  stl_cmd_t                      cmd_i,
  output stl_stat_t                     stat_o,
  stl_out_if.source                     out_o
);
  logic [FUNC_W-1:0]             func_q, func_d;
  logic signed [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d, idx_q, idx_d, kept_q, kept_d;
  logic [CNT_W-1:0]              first_q, first_d, lastx_q, lastx_d;
  logic                          hit_q, hit_d, desc_q, desc_d;
  logic                          ov_q, ov_d;
  logic [STATUS_W-1:0]           ost_q, ost_d;
  logic [POS_W-1:0]              opos_q, opos_d, ocnt_q, ocnt_d;
  logic signed [VALUE_WIDTH-1:0] oval_q, oval_d;
  logic                          olast_q, olast_d;

  logic                          we;
  logic [ADDR_W-1:0]             waddr, raddr;
  logic [VALUE_WIDTH-1:0]        wdata, rdata;
  logic signed [VALUE_WIDTH-1:0] rd_s;
  logic                          scan_end;
  logic [CNT_W-1:0]              ridx;
  route_e                        start_route, eval_next;
  logic                          out_free, eval_ok;

  stl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.read),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_s     = $signed(rdata);
  assign scan_end = (idx_q == cnt_q - CNT_W'(1));
  assign out_free = !ov_q || out_o.ready;
  assign eval_ok  = (func_q != FN_DUMP) || out_free;
  assign stat_o   = '{start_route: start_route, eval_next: eval_next,
                      eval_ok: eval_ok, out_free: out_free};

  // read address: insert walks down from the top, dump may walk backward
  always_comb begin
    ridx = idx_q;
    case (func_q)
      FN_INSERT: ridx = idx_q - CNT_W'(1);
      FN_DUMP:   ridx = desc_q ? (cnt_q - CNT_W'(1) - idx_q) : idx_q;
      default:   ridx = idx_q;
    endcase
  end
  assign raddr = ridx[ADDR_W-1:0];

  always_comb begin
    start_route = RT_RES;
    case (in_func_i)
      FN_INSERT: begin
        if (cnt_q == CNT_W'(CAPACITY)) start_route = RT_RES;
        else if (cnt_q == '0)          start_route = RT_PLACE;
        else                           start_route = RT_READ;
      end
      FN_DELETE, FN_FIND, FN_DUMP: begin
        start_route = (cnt_q == '0) ? RT_RES : RT_READ;
      end
      default: start_route = RT_RES;
    endcase
  end

  always_comb begin
    eval_next = RT_READ;
    case (func_q)
      FN_INSERT: begin
        if (!(rd_s > val_q) || idx_q == CNT_W'(1)) eval_next = RT_PLACE;
      end
      FN_DUMP: if (scan_end) eval_next = RT_IDLE;
      default: if (scan_end) eval_next = RT_RES;
    endcase
  end

  always_comb begin
    func_d  = func_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    kept_d  = kept_q;
    first_d = first_q;
    lastx_d = lastx_q;
    hit_d   = hit_q;
    desc_d  = desc_q;
    ov_d    = ov_q && !out_o.ready;
    ost_d   = ost_q;
    opos_d  = opos_q;
    ocnt_d  = ocnt_q;
    oval_d  = oval_q;
    olast_d = olast_q;
    we      = 1'b0;
    waddr   = idx_q[ADDR_W-1:0];
    wdata   = rdata;

    if (cmd_i.load) begin
      func_d = in_func_i;
      val_d  = in_value_i;
      idx_d  = (in_func_i == FN_INSERT) ? cnt_q : '0;
      kept_d = '0;
      hit_d  = 1'b0;
    end

    if (cmd_i.eval) begin
      case (func_q)
        FN_INSERT: begin
          if (rd_s > val_q) begin
            we    = 1'b1;
            idx_d = idx_q - CNT_W'(1);
          end
        end
        FN_DELETE: begin
          if (rd_s != val_q) begin
            we     = 1'b1;
            waddr  = kept_q[ADDR_W-1:0];
            kept_d = kept_q + CNT_W'(1);
          end
          idx_d = idx_q + CNT_W'(1);
        end
        FN_FIND: begin
          if (rd_s == val_q) begin
            if (!hit_q) first_d = idx_q;
            lastx_d = idx_q;
            hit_d   = 1'b1;
          end
          idx_d = idx_q + CNT_W'(1);
        end
        FN_DUMP: begin
          ov_d    = 1'b1;
          ost_d   = ST_OK;
          opos_d  = POS_W'(idx_q + CNT_W'(1));
          oval_d  = rd_s;
          ocnt_d  = POS_W'(cnt_q);
          olast_d = scan_end;
          idx_d   = idx_q + CNT_W'(1);
        end
        default: idx_d = idx_q;
      endcase
    end

    if (cmd_i.place) begin
      we    = 1'b1;
      wdata = val_q;
      cnt_d = cnt_q + CNT_W'(1);
      // mark the insert as placed so a table that just became full reports ok
      hit_d = 1'b1;
    end

    if (cmd_i.result) begin
      ov_d    = 1'b1;
      ost_d   = ST_OK;
      opos_d  = '0;
      oval_d  = '0;
      olast_d = 1'b1;
      case (func_q)
        FN_INSERT: if (!hit_q) ost_d = ST_FULL;
        FN_DELETE: begin
          cnt_d = kept_q;
          ost_d = (kept_q != cnt_q) ? ST_OK : ST_MISS;
        end
        FN_FIND: begin
          if (hit_q) begin
            opos_d = desc_q ? POS_W'(cnt_q - lastx_q) : POS_W'(first_q + CNT_W'(1));
            oval_d = val_q;
          end else begin
            ost_d = ST_MISS;
          end
        end
        FN_REVERSE: desc_d = !desc_q;
        FN_DUMP:    ost_d = ST_MISS;
        default:    ost_d = ST_OK;
      endcase
      ocnt_d = POS_W'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      desc_q <= 1'b0;
      ov_q   <= 1'b0;
      hit_q  <= 1'b0;
      idx_q  <= '0;
      kept_q <= '0;
      func_q <= FN_INSERT;
    end else begin
      cnt_q  <= cnt_d;
      desc_q <= desc_d;
      ov_q   <= ov_d;
      hit_q  <= hit_d;
      idx_q  <= idx_d;
      kept_q <= kept_d;
      func_q <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    first_q <= first_d;
    lastx_q <= lastx_d;
    ost_q   <= ost_d;
    opos_q  <= opos_d;
    ocnt_q  <= ocnt_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.status      = ost_q;
  assign out_o.position    = opos_q;
  assign out_o.item_value  = oval_q;
  assign out_o.entry_count = ocnt_q;
  assign out_o.last        = olast_q;
endmodule

FILE: rtl/core/stl_ctrl.sv
`timescale 1ns / 1ps
module stl_ctrl
  import stl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  stl_stat_t stat_i,
  output stl_cmd_t  cmd_o
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_EVAL  = 5'b00100,
    S_PLACE = 5'b01000,
    S_RES   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  function automatic state_e route_to_state(route_e r);
    state_e s;
    case (r)
      RT_READ:  s = S_READ;
      RT_PLACE: s = S_PLACE;
      RT_RES:   s = S_RES;
      default:  s = S_IDLE;
    endcase
    return s;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = route_to_state(stat_i.start_route);
        end
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        // hold the read data while a dump entry cannot be handed over
        if (stat_i.eval_ok) begin
          cmd_o.eval = 1'b1;
          state_d    = route_to_state(stat_i.eval_next);
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_RES;
      end
      S_RES: begin
        if (stat_i.out_free) begin
          cmd_o.result = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

FILE: rtl/core/sorted_list_table.sv
`timescale 1ns / 1ps
// Sorted list table: a multiset of up to 64 signed 32-bit values kept in
// ascending order (descending after an odd number of reverse commands).
// Input channel in_i: func (insert, delete all equal, find, reverse, dump)
// and value. Output channel out_o: status, position, item_value,
// entry_count and last; every command ends with a result marked last.
// The entries sit in one single-port-write RAM with registered read; each
// entry visited takes a read step, then a compare/move step. Reverse, a
// full insert, and delete, find or dump on an empty table go straight to
// the result; insert walks down past the entries above the new value, then
// places it; delete and find walk all entries held; dump hands out one
// entry per visit and waits while the output register is still full.
// One command is worked at a time; a new one is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// Reset empties the table and selects ascending order; RAM contents are
// not cleared since only entries below the count are ever read.
// Output stalls hold the output register and stop work at the next output.
module sorted_list_table
  import stl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  stl_in_if.sink     in_i,
  stl_out_if.source  out_o
);
  stl_cmd_t  cmd;
  stl_stat_t stat;

  stl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  stl_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_func_i (in_i.func),
    .in_value_i(in_i.value),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_o     (out_o)
  );
endmodule

FILE: rtl/core/stl_checker.sv
`timescale 1ns / 1ps
module stl_checker
  import stl_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  stl_in_if.sink    in_i,
  stl_out_if.source out_o
);
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.entry_count <= POS_W'(CAPACITY))
    else $error("entry_count beyond capacity");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.position <= out_o.entry_count)
    else $error("position beyond entry_count");

  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != ST_OK) |-> (out_o.last && out_o.position == '0))
    else $error("failed result not final or has position");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.item_value)))
    else $error("stalled result changed");

  // the input is never ready in the cycle after a command is taken
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken on consecutive cycles");
endmodule

bind sorted_list_table stl_checker u_stl_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .in_i  (in_i),
  .out_o (out_o)
);
